### hdl/abmh_pkg.sv
package abmh_pkg;

    localparam int unsigned BLOCK_SAMPLES      = 64;
    localparam int unsigned SAMPLES_PER_COLUMN = 16;
    localparam int unsigned WAVE_COLUMNS       = 32;
    localparam int unsigned MAX_READ           = 32;
    localparam int unsigned READ_COLUMNS       =
        (WAVE_COLUMNS < MAX_READ) ? WAVE_COLUMNS : MAX_READ;

    localparam int unsigned RAW_W   = 12;
    localparam int unsigned MV_W    = 16;
    localparam int unsigned ALPHA_W = 16;
    localparam int unsigned AVG_W   = 32;
    localparam int unsigned IDX_W   = 5;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned DATA_W  = 32;

    localparam int unsigned RAW_ACC_W = RAW_W + $clog2(BLOCK_SAMPLES);
    localparam int unsigned MV_ACC_W  = MV_W + $clog2(BLOCK_SAMPLES);
    localparam int unsigned BLK_CNT_W =
        (BLOCK_SAMPLES > 1) ? $clog2(BLOCK_SAMPLES) : 1;
    localparam int unsigned BKT_CNT_W =
        (SAMPLES_PER_COLUMN > 1) ? $clog2(SAMPLES_PER_COLUMN) : 1;
    localparam int unsigned FILL_W    = $clog2(WAVE_COLUMNS + 1);
    localparam int unsigned RD_CNT_W  =
        (WAVE_COLUMNS > 1) ? $clog2(WAVE_COLUMNS) : 1;

    localparam int unsigned PROD_W = AVG_W + 1 + ALPHA_W + 1;

    localparam logic [1:0] REG_ALPHA   = 2'd0;
    localparam logic [1:0] REG_RAW_LIM = 2'd1;
    localparam logic [1:0] REG_MV_LIM  = 2'd2;

    localparam logic [ALPHA_W-1:0] ALPHA_RST   = 16'd6554;
    localparam logic [RAW_W-1:0]   RAW_LIM_RST = 12'd4000;
    localparam logic [MV_W-1:0]    MV_LIM_RST  = 16'd3050;

    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_READ   = 1'b1;

    typedef struct packed {
        logic [MV_W-1:0] lo;
        logic [MV_W-1:0] hi;
    } t_col;

    typedef struct packed {
        logic shift;
        logic load;
    } t_cell_ctl;

    typedef struct packed {
        logic              push;
        logic              rotate;
        logic [FILL_W-1:0] fill;
    } t_chain_ctl;

endpackage

### hdl/abmh_cell.sv
module abmh_cell (
    input  logic                 i_clk,
    input  abmh_pkg::t_cell_ctl  i_ctl,
    input  abmh_pkg::t_col       i_nbr,
    input  abmh_pkg::t_col       i_new,
    output abmh_pkg::t_col       o_col
);

    abmh_pkg::t_col r_col;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_col <= i_nbr;
        end else if (i_ctl.load) begin
            r_col <= i_new;
        end
    end

    assign o_col = r_col;

endmodule

### hdl/abmh_chain.sv
module abmh_chain (
    input  logic                 i_clk,
    input  abmh_pkg::t_chain_ctl i_ctl,
    input  abmh_pkg::t_col       i_new,
    output abmh_pkg::t_col       o_head
);

    abmh_pkg::t_col cols [abmh_pkg::WAVE_COLUMNS];
    logic           full;

    assign full = (i_ctl.fill == abmh_pkg::FILL_W'(abmh_pkg::WAVE_COLUMNS));

    // oldest column sits in cell 0 whenever no readout is rotating the chain
    for (genvar k = 0; k < abmh_pkg::WAVE_COLUMNS; k++) begin : g_cell
        abmh_pkg::t_cell_ctl ctl;
        abmh_pkg::t_col      nbr;

        assign ctl.shift = i_ctl.rotate | (i_ctl.push & full);
        assign ctl.load  = i_ctl.push & ~full &
                           (i_ctl.fill == abmh_pkg::FILL_W'(k));

        if (k == abmh_pkg::WAVE_COLUMNS - 1) begin : g_tail
            assign nbr = i_ctl.rotate ? cols[0] : i_new;
        end else begin : g_body
            assign nbr = cols[k+1];
        end

        abmh_cell u_cell (
            .i_clk (i_clk),
            .i_ctl (ctl),
            .i_nbr (nbr),
            .i_new (i_new),
            .o_col (cols[k])
        );
    end

    assign o_head = cols[0];

endmodule

### hdl/adc_block_average_minmax_history.sv
// Block averager with min/max waveform history. A sample word (req_type 0)
// is accepted and returns one result word through the S_EMIT state, or,
// when it closes a block of 64 samples, through S_MUL (the moving-average
// multiply), S_ADD (the accumulate) and S_EMIT; the first block skips S_ADD,
// as S_MUL loads the average directly. A readout word (req_type 1)
// returns 32 result words, oldest column first, one per cycle while the output
// is not stalled; the history is a chain of 32 cells that rotates once per
// result, so a readout occupies the block until its last result. A new word
// is taken as soon as the previous one has been handed to the output register.
// Registers: 0x0 alpha (Q0.16), 0x4 raw limit, 0x8 millivolt limit.
module adc_block_average_minmax_history (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_req_type,
    input  logic [abmh_pkg::RAW_W-1:0]   i_raw_code,
    input  logic [abmh_pkg::MV_W-1:0]    i_sample_mv,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_block_done,
    output logic [abmh_pkg::RAW_W-1:0]   o_raw_mean,
    output logic [abmh_pkg::MV_W-1:0]    o_filtered_mv,
    output logic                         o_filter_valid,
    output logic                         o_near_limit,
    output logic [abmh_pkg::FILL_W-1:0]  o_wave_fill,
    output logic [abmh_pkg::IDX_W-1:0]   o_column_index,
    output logic [abmh_pkg::MV_W-1:0]    o_column_min,
    output logic [abmh_pkg::MV_W-1:0]    o_column_max,
    output logic                         o_last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [abmh_pkg::ADDR_W-1:0]  paddr,
    input  logic [abmh_pkg::DATA_W-1:0]  pwdata,
    output logic [abmh_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ADD  = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;

    localparam int unsigned RAW_W   = abmh_pkg::RAW_W;
    localparam int unsigned MV_W    = abmh_pkg::MV_W;
    localparam int unsigned AVG_W   = abmh_pkg::AVG_W;
    localparam int unsigned PROD_W  = abmh_pkg::PROD_W;
    localparam int unsigned Q_W     = PROD_W - 16;
    localparam int unsigned SUM_W   = AVG_W + 3;

    logic [2:0]                          r_state;
    logic [abmh_pkg::ALPHA_W-1:0]        r_alpha;
    logic [RAW_W-1:0]                    r_raw_lim;
    logic [MV_W-1:0]                     r_mv_lim;
    logic [abmh_pkg::RAW_ACC_W-1:0]      r_raw_acc;
    logic [abmh_pkg::MV_ACC_W-1:0]       r_mv_acc;
    logic [abmh_pkg::BLK_CNT_W-1:0]      r_blk_cnt;
    logic [abmh_pkg::BKT_CNT_W-1:0]      r_bkt_cnt;
    logic [MV_W-1:0]                     r_bkt_lo;
    logic [MV_W-1:0]                     r_bkt_hi;
    logic [abmh_pkg::FILL_W-1:0]         r_fill;
    logic [RAW_W-1:0]                    r_mean_raw;
    logic [AVG_W-1:0]                    r_mean_q16;
    logic [AVG_W-1:0]                    r_avg;
    logic                                r_avg_ready;
    logic                                r_blk_flag;
    logic                                r_latched;
    logic                                r_done;
    logic [abmh_pkg::RD_CNT_W-1:0]       r_rd_cnt;
    logic signed [PROD_W-1:0]            r_prod;
    logic                                r_ovalid;

    logic [abmh_pkg::RAW_ACC_W-1:0]      raw_sum;
    logic [abmh_pkg::MV_ACC_W-1:0]       mv_sum;
    logic [abmh_pkg::RAW_ACC_W:0]        raw_round;
    logic [MV_W-1:0]                     lo_new;
    logic [MV_W-1:0]                     hi_new;
    logic                                flag_new;
    logic                                blk_close;
    logic                                bkt_close;
    logic                                accept;
    logic                                acc_sample;
    logic                                acc_read;
    logic                                out_free;
    logic                                rd_live;
    logic                                rd_step;
    logic                                rd_filled;
    logic                                load_out;
    logic signed [AVG_W:0]               diff;
    logic signed [PROD_W-1:0]            t_round;
    logic signed [SUM_W-1:0]             avg_sum;
    logic [AVG_W:0]                      avg_half;
    logic [MV_W-1:0]                     filt_mv;
    logic                                cfg_wr;
    abmh_pkg::t_chain_ctl                chain_ctl;
    abmh_pkg::t_col                      col_new;
    abmh_pkg::t_col                      col_head;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        case (paddr[3:2])
            abmh_pkg::REG_ALPHA:   prdata = abmh_pkg::DATA_W'(r_alpha);
            abmh_pkg::REG_RAW_LIM: prdata = abmh_pkg::DATA_W'(r_raw_lim);
            abmh_pkg::REG_MV_LIM:  prdata = abmh_pkg::DATA_W'(r_mv_lim);
            default:               prdata = '0;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid & ~o_in_stall;
    assign acc_sample = accept & (i_req_type == abmh_pkg::REQ_SAMPLE);
    assign acc_read   = accept & (i_req_type == abmh_pkg::REQ_READ);
    assign out_free   = ~r_ovalid | ~i_out_stall;

    assign raw_sum   = r_raw_acc + abmh_pkg::RAW_ACC_W'(i_raw_code);
    assign mv_sum    = r_mv_acc + abmh_pkg::MV_ACC_W'(i_sample_mv);
    assign raw_round = {1'b0, raw_sum} +
                       (abmh_pkg::RAW_ACC_W+1)'(abmh_pkg::BLOCK_SAMPLES / 2);
    assign flag_new  = r_blk_flag | (i_raw_code >= r_raw_lim) | (i_sample_mv >= r_mv_lim);
    assign lo_new    = (i_sample_mv < r_bkt_lo) ? i_sample_mv : r_bkt_lo;
    assign hi_new    = (i_sample_mv > r_bkt_hi) ? i_sample_mv : r_bkt_hi;
    assign blk_close = (r_blk_cnt == abmh_pkg::BLK_CNT_W'(abmh_pkg::BLOCK_SAMPLES - 1));
    assign bkt_close = (r_bkt_cnt == abmh_pkg::BKT_CNT_W'(abmh_pkg::SAMPLES_PER_COLUMN - 1));

    assign rd_live   = (32'(r_rd_cnt) < abmh_pkg::READ_COLUMNS);
    assign rd_step   = (r_state == S_READ) & (~rd_live | out_free);
    assign rd_filled = (abmh_pkg::FILL_W'(r_rd_cnt) < r_fill);
    assign load_out  = ((r_state == S_EMIT) & out_free) | (rd_step & rd_live);

    assign col_new.lo       = lo_new;
    assign col_new.hi       = hi_new;
    assign chain_ctl.push   = acc_sample & bkt_close;
    assign chain_ctl.rotate = rd_step;
    assign chain_ctl.fill   = r_fill;

    abmh_chain u_chain (
        .i_clk  (i_clk),
        .i_ctl  (chain_ctl),
        .i_new  (col_new),
        .o_head (col_head)
    );

    assign diff     = $signed({1'b0, r_mean_q16}) - $signed({1'b0, r_avg});
    assign t_round  = r_prod + PROD_W'(32768);
    assign avg_sum  = $signed({3'b000, r_avg}) +
                      $signed({{(SUM_W-Q_W){t_round[PROD_W-1]}}, t_round[PROD_W-1:16]});
    assign avg_half = {1'b0, r_avg} + (AVG_W+1)'(32768);
    assign filt_mv  = avg_half[AVG_W] ? {MV_W{1'b1}} : avg_half[AVG_W-1:16];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_alpha     <= abmh_pkg::ALPHA_RST;
            r_raw_lim   <= abmh_pkg::RAW_LIM_RST;
            r_mv_lim    <= abmh_pkg::MV_LIM_RST;
            r_raw_acc   <= '0;
            r_mv_acc    <= '0;
            r_blk_cnt   <= '0;
            r_bkt_cnt   <= '0;
            r_bkt_lo    <= '1;
            r_bkt_hi    <= '0;
            r_fill      <= '0;
            r_mean_raw  <= '0;
            r_avg       <= '0;
            r_avg_ready <= 1'b0;
            r_blk_flag  <= 1'b0;
            r_latched   <= 1'b0;
            r_done      <= 1'b0;
            r_rd_cnt    <= '0;
            r_ovalid    <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (paddr[3:2])
                    abmh_pkg::REG_ALPHA:   r_alpha   <= pwdata[abmh_pkg::ALPHA_W-1:0];
                    abmh_pkg::REG_RAW_LIM: r_raw_lim <= pwdata[RAW_W-1:0];
                    abmh_pkg::REG_MV_LIM:  r_mv_lim  <= pwdata[MV_W-1:0];
                    default: ;
                endcase
            end

            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end

            if (acc_sample) begin
                if (bkt_close) begin
                    r_bkt_cnt <= '0;
                    r_bkt_lo  <= '1;
                    r_bkt_hi  <= '0;
                    if (r_fill != abmh_pkg::FILL_W'(abmh_pkg::WAVE_COLUMNS)) begin
                        r_fill <= r_fill + 1'b1;
                    end
                end else begin
                    r_bkt_cnt <= r_bkt_cnt + 1'b1;
                    r_bkt_lo  <= lo_new;
                    r_bkt_hi  <= hi_new;
                end
                if (blk_close) begin
                    r_raw_acc  <= '0;
                    r_mv_acc   <= '0;
                    r_blk_cnt  <= '0;
                    r_mean_raw <= RAW_W'(raw_round / abmh_pkg::BLOCK_SAMPLES);
                    r_latched  <= flag_new;
                    r_blk_flag <= 1'b0;
                    r_done     <= 1'b1;
                    r_state    <= S_MUL;
                end else begin
                    r_raw_acc  <= raw_sum;
                    r_mv_acc   <= mv_sum;
                    r_blk_cnt  <= r_blk_cnt + 1'b1;
                    r_blk_flag <= flag_new;
                    r_done     <= 1'b0;
                    r_state    <= S_EMIT;
                end
            end

            if (acc_read) begin
                r_rd_cnt <= '0;
                r_state  <= S_READ;
            end

            case (r_state)
                S_MUL: begin
                    if (!r_avg_ready) begin
                        r_avg       <= r_mean_q16;
                        r_avg_ready <= 1'b1;
                        r_state     <= S_EMIT;
                    end else begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    if (avg_sum[SUM_W-1]) begin
                        r_avg <= '0;
                    end else if (avg_sum[SUM_W-2:AVG_W] != '0) begin
                        r_avg <= '1;
                    end else begin
                        r_avg <= avg_sum[AVG_W-1:0];
                    end
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_READ: begin
                    if (rd_step) begin
                        r_rd_cnt <= r_rd_cnt + 1'b1;
                        if (r_rd_cnt == abmh_pkg::RD_CNT_W'(abmh_pkg::WAVE_COLUMNS - 1)) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_sample && blk_close) begin
            r_mean_q16 <= AVG_W'({mv_sum, 16'h0000} / abmh_pkg::BLOCK_SAMPLES);
        end
        if (r_state == S_MUL) begin
            r_prod <= diff * $signed({1'b0, r_alpha});
        end
        if (load_out) begin
            o_raw_mean     <= r_mean_raw;
            o_filtered_mv  <= filt_mv;
            o_filter_valid <= r_avg_ready;
            o_near_limit   <= r_latched;
            o_wave_fill    <= r_fill;
            if (r_state == S_READ) begin
                o_block_done   <= 1'b0;
                o_column_index <= abmh_pkg::IDX_W'(r_rd_cnt);
                o_column_min   <= rd_filled ? col_head.lo : '0;
                o_column_max   <= rd_filled ? col_head.hi : '0;
                o_last         <= (r_rd_cnt == abmh_pkg::RD_CNT_W'(abmh_pkg::READ_COLUMNS - 1));
            end else begin
                o_block_done   <= r_done;
                o_column_index <= '0;
                o_column_min   <= '0;
                o_column_max   <= '0;
                o_last         <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_ovalid;

endmodule

### hdl/abmh_checker.sv
module abmh_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         o_in_stall,
    input  logic                         i_req_type,
    input  logic [abmh_pkg::RAW_W-1:0]   i_raw_code,
    input  logic [abmh_pkg::MV_W-1:0]    i_sample_mv,
    input  logic                         o_out_valid,
    input  logic                         i_out_stall,
    input  logic                         o_block_done,
    input  logic [abmh_pkg::RAW_W-1:0]   o_raw_mean,
    input  logic [abmh_pkg::MV_W-1:0]    o_filtered_mv,
    input  logic                         o_filter_valid,
    input  logic                         o_near_limit,
    input  logic [abmh_pkg::FILL_W-1:0]  o_wave_fill,
    input  logic [abmh_pkg::IDX_W-1:0]   o_column_index,
    input  logic [abmh_pkg::MV_W-1:0]    o_column_min,
    input  logic [abmh_pkg::MV_W-1:0]    o_column_max,
    input  logic                         o_last,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [abmh_pkg::ADDR_W-1:0]  paddr,
    input  logic [abmh_pkg::DATA_W-1:0]  pwdata,
    input  logic [abmh_pkg::DATA_W-1:0]  prdata,
    input  logic                         pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last |-> !o_block_done)
        else $error("readout word flagged block done");

    a_empty_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ({1'b0, o_column_index} >= o_wave_fill)
        |-> (o_column_min == '0) && (o_column_max == '0))
        else $error("unfilled column not zero");

    a_col_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last && !i_out_stall
        |=> o_out_valid &&
            (o_column_index == abmh_pkg::IDX_W'($past(o_column_index) + 1'b1)))
        else $error("readout column sequence broken");

    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_block_done |-> o_filter_valid)
        else $error("block done without valid filter");

endmodule

bind adc_block_average_minmax_history abmh_checker u_abmh_checker (.*);
